[rtl/core/swr_pkg.sv]
`default_nettype none
package swr_pkg;
   localparam int RandWidth  = 31;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 7;

   typedef enum logic [1:0] {
      CSR_RANGE_MIN    = 2'd0,
      CSR_RANGE_SIZE   = 2'd1,
      CSR_SAMPLE_COUNT = 2'd2,
      CSR_NO_REPEATS   = 2'd3
   } csr_index_type;

   // broadcast request to every cell of the chain
   typedef struct packed {
      logic                  lookup;   // compare key, report hit
      logic                  write;    // write value where key hits
      logic                  append;   // append key/value at fill point
      logic [RandWidth-1:0]  key;
      logic [ValueWidth-1:0] value;
   } cell_cmd_type;
endpackage
`default_nettype wire

[rtl/core/sample_without_replacement.sv]
// Draws one number per random word over range_min .. range_min+range_size-1.
// With no_repeats set and sample_count <= range_size the draws of a run are
// distinct (sparse partial Fisher-Yates): offsets below the count sit in a
// slot memory, higher offsets in a chain of MAX_DRAWS spill cells that each
// hold one offset/value pair and pass lookup hits to their neighbour. A
// spill offset goes through a bit-serial modulo, then the hit ripple through
// the whole cell chain; a slot offset and an independent draw skip the chain.
// The next word is taken once the result has been accepted. A configuration
// write ends the run.
`default_nettype none
module sample_without_replacement
   import swr_pkg::*;
#(
   parameter int MAX_DRAWS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // rand_word[30:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,   // drawn_value[31:0], draw_number[37:32]
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [31:0]           csr_data
);
   localparam int IdxWidth = $clog2(MAX_DRAWS);
   localparam int CntW     = $clog2(MAX_DRAWS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_READ, S_SPILL, S_WAIT, S_DONE, S_OUT
   } state_type;

   state_type             state_ff;
   logic signed [31:0]    min_ff;
   logic [RandWidth-1:0]  size_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  norep_ff;
   logic [IdxWidth-1:0]   step_ff;
   logic [RandWidth-1:0]  j_ff;
   logic [ValueWidth-1:0] cur_ff, res_ff;
   logic                  hit_ff;
   logic [CntW-1:0]       wait_ff;
   logic [MAX_DRAWS-1:0]  touched_ff;
   logic [ValueWidth-1:0] slot_mem [MAX_DRAWS];
   logic [ValueWidth-1:0] rd_i_ff, rd_j_ff;
   logic [39:0]           out_data_ff;
   logic                  out_last_ff, out_valid_ff, fin_now;

   logic [RandWidth-1:0]  eff_size;
   logic [CntW-1:0]       eff_count;
   logic                  shuffle;
   logic [RandWidth-1:0]  div_a, div_b, rem;
   logic                  div_start, div_done;
   logic                  cfg_wr, clear_cells;
   cell_cmd_type          cmd;
   logic [MAX_DRAWS:0]    used_chain;
   logic [MAX_DRAWS:0]    hit_chain;
   logic [ValueWidth-1:0] val_chain [MAX_DRAWS+1];
   logic [RandWidth-1:0]  step_ext;
   logic                  j_in_slots;

   assign eff_size  = (size_ff == '0) ? RandWidth'(1) : size_ff;
   always_comb begin
      if (count_ff == '0) eff_count = CntW'(1);
      else if ({{(32-CountWidth){1'b0}}, count_ff} > 32'(MAX_DRAWS)) eff_count = CntW'(MAX_DRAWS);
      else eff_count = CntW'(count_ff);
   end
   assign shuffle  = norep_ff && ({{(32-CntW){1'b0}}, eff_count} <= {1'b0, eff_size});
   assign step_ext = RandWidth'(step_ff);
   assign j_in_slots = ({1'b0, j_ff} < 32'(eff_count));

   assign csr_ready  = !reset && (state_ff == S_IDLE) && !out_valid_ff;
   assign cfg_wr     = csr_valid && csr_ready;
   assign req_tready = !reset && (state_ff == S_IDLE) && !out_valid_ff && !cfg_wr;
   assign div_start  = req_tvalid && req_tready;
   assign div_a      = req_tdata[RandWidth-1:0];
   assign div_b      = shuffle ? (eff_size - step_ext) : eff_size;

   swr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .remainder(rem)
   );

   always_comb begin
      cmd        = '0;
      cmd.key    = j_ff;
      cmd.value  = cur_ff;
      cmd.lookup = (state_ff == S_SPILL);
      cmd.write  = (state_ff == S_DONE) && !j_in_slots && hit_ff;
      cmd.append = (state_ff == S_DONE) && !j_in_slots && !hit_ff;
   end

   assign clear_cells  = cfg_wr || ((state_ff == S_OUT) && fin_now);
   assign used_chain[0] = 1'b1;
   assign hit_chain[MAX_DRAWS] = 1'b0;
   assign val_chain[MAX_DRAWS] = '0;

   for (genvar g = 0; g < MAX_DRAWS; g++) begin : g_cell
      swr_spill_cell u_cell (
         .clock(clock), .reset(reset), .clear(clear_cells), .cmd(cmd),
         .prev_used(used_chain[g]), .hit_in(hit_chain[g+1]),
         .value_in(val_chain[g+1]), .used(used_chain[g+1]),
         .hit_out(hit_chain[g]), .value_out(val_chain[g])
      );
   end

   // slot memory: read two addresses, registered
   always_ff @(posedge clock) begin
      rd_i_ff <= slot_mem[step_ff];
      rd_j_ff <= slot_mem[j_ff[IdxWidth-1:0]];
      if (state_ff == S_DONE && shuffle) begin
         if (j_in_slots) slot_mem[j_ff[IdxWidth-1:0]] <= cur_ff;
      end else if (state_ff == S_OUT && shuffle) begin
         slot_mem[step_ff] <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_ff       <= '0;
         size_ff      <= RandWidth'(1);
         count_ff     <= CountWidth'(1);
         norep_ff     <= 1'b0;
         step_ff      <= '0;
         touched_ff   <= '0;
         out_valid_ff <= 1'b0;
         wait_ff      <= '0;
      end else begin
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         if (cfg_wr) begin
            case (csr_index_type'(csr_index))
               CSR_RANGE_MIN:    min_ff   <= csr_data;
               CSR_RANGE_SIZE:   size_ff  <= csr_data[RandWidth-1:0];
               CSR_SAMPLE_COUNT: count_ff <= csr_data[CountWidth-1:0];
               CSR_NO_REPEATS:   norep_ff <= csr_data[0];
               default:          ;
            endcase
            step_ff    <= '0;
            touched_ff <= '0;
         end
         case (state_ff)
            S_IDLE: if (div_start) state_ff <= S_DIV;
            S_DIV: if (div_done) begin
               j_ff     <= shuffle ? step_ext + rem : rem;
               state_ff <= S_READ;
               wait_ff  <= '0;
            end
            S_READ: begin
               // address settles first, then the registered read data is used
               wait_ff <= wait_ff + 1'b1;
               if (wait_ff == CntW'(1)) begin
                  cur_ff <= touched_ff[step_ff] ? rd_i_ff : min_ff + 32'(step_ff);
                  if (!shuffle) begin
                     res_ff   <= min_ff + {1'b0, j_ff};
                     state_ff <= S_OUT;
                  end else if (j_in_slots) begin
                     res_ff   <= touched_ff[j_ff[IdxWidth-1:0]] ? rd_j_ff
                                 : min_ff + {1'b0, j_ff};
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SPILL;
                  end
               end
            end
            S_SPILL: begin
               wait_ff  <= '0;
               hit_ff   <= 1'b0;
               res_ff   <= min_ff + {1'b0, j_ff};
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               // a hit passes the chain head once, so catch it whenever it comes
               wait_ff <= wait_ff + 1'b1;
               if (hit_chain[0]) begin
                  res_ff <= val_chain[0];
                  hit_ff <= 1'b1;
               end
               if (wait_ff == CntW'(MAX_DRAWS - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (j_in_slots) touched_ff[j_ff[IdxWidth-1:0]] <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               out_data_ff  <= {2'b00, 6'(step_ff), res_ff};
               out_last_ff  <= fin_now;
               out_valid_ff <= 1'b1;
               if (fin_now) begin
                  step_ff    <= '0;
                  touched_ff <= '0;
               end else begin
                  step_ff <= step_ff + 1'b1;
                  if (shuffle) touched_ff[step_ff] <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign fin_now = ({1'b0, step_ff} + 1'b1) >= (IdxWidth+1)'(eff_count);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready with result pending");
   a_div_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_DIV) else $error("no divide start");
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> state_ff == S_IDLE) else $error("config while busy");
endmodule
`default_nettype wire

[rtl/core/swr_divider.sv]
`default_nettype none
module swr_divider
   import swr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [RandWidth-1:0] dividend,
   input  wire logic [RandWidth-1:0] divisor,
   output logic                      done,
   output logic [RandWidth-1:0]      remainder
);
   localparam int CntWidth = $clog2(RandWidth + 1);

   logic [RandWidth-1:0] quot_ff, quot_in;
   logic [RandWidth:0]   rem_ff, rem_in;
   logic [RandWidth-1:0] div_ff, div_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RandWidth:0]   trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[RandWidth-1:0], quot_ff[RandWidth-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CntWidth'(RandWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[RandWidth-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[RandWidth-1:0];
endmodule
`default_nettype wire

[rtl/core/swr_spill_cell.sv]
`default_nettype none
module swr_spill_cell
   import swr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire cell_cmd_type          cmd,
   input  wire logic                  prev_used,  // left neighbour holds an entry
   input  wire logic                  hit_in,     // hit data from right neighbour
   input  wire logic [ValueWidth-1:0] value_in,
   output logic                       used,
   output logic                       hit_out,
   output logic [ValueWidth-1:0]      value_out
);
   logic                  used_ff;
   logic [RandWidth-1:0]  key_ff;
   logic [ValueWidth-1:0] value_ff;
   logic                  match;

   assign match = used_ff && (key_ff == cmd.key);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         used_ff <= 1'b0;
      end else if (cmd.append && prev_used && !used_ff) begin
         used_ff <= 1'b1;
      end
      if (cmd.append && prev_used && !used_ff) begin
         key_ff   <= cmd.key;
         value_ff <= cmd.value;
      end else if (cmd.write && match) begin
         value_ff <= cmd.value;
      end
   end

   // hit result ripples leftward one cell per cycle
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hit_out <= 1'b0;
      end else if (cmd.lookup && match) begin
         hit_out <= 1'b1;
      end else begin
         hit_out <= hit_in;
      end
      value_out <= (cmd.lookup && match) ? value_ff : value_in;
   end

   assign used = used_ff;
endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb;
   import swr_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      logic [5:0]  position;
      logic        final_draw;
   } draw_type;

   typedef struct {
      logic [30:0] word;
      logic        known;
      draw_type    draw;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_index_type csr_index = CSR_RANGE_MIN;
   logic [31:0] csr_data = '0;

   sample_without_replacement dut (.*);

   always #6 clock = ~clock;

   // shadow of the block's settings and run state
   logic [31:0] lo_value;
   logic [30:0] span;
   logic [6:0]  draws_per_run;
   logic        distinct;
   int unsigned step_pos;
   logic [31:0] slot_val [64];
   bit          slot_set [64];
   logic [30:0] spill_key [64];
   logic [31:0] spill_val [64];
   int unsigned spill_fill;

   draw_type pending_draws [$];
   int     failures = 0;
   bit     hold_long = 0;
   bit     sending = 0;
   int unsigned lag_cycles = 0;

   function automatic void clear_shuffle();
      step_pos = 0;
      spill_fill = 0;
      foreach (slot_set[k]) slot_set[k] = 0;
   endfunction

   function automatic logic [31:0] slot_read(int unsigned k);
      return slot_set[k] ? slot_val[k] : lo_value + k;
   endfunction

   function automatic draw_type next_draw(logic [30:0] word);
      int unsigned size, cnt, i, j, k, cur, res;
      bit hit;
      draw_type d;
      size = (span == 0) ? 1 : span;
      cnt = (draws_per_run == 0) ? 1 : (draws_per_run > 64 ? 64 : draws_per_run);
      i = step_pos;
      if (i >= cnt) begin
         clear_shuffle();
         i = 0;
      end
      if (distinct && cnt <= size) begin
         j = i + word % (size - i);
         cur = slot_read(i);
         if (j < cnt) begin
            res = slot_read(j);
            slot_val[j] = cur;
            slot_set[j] = 1;
         end else begin
            hit = 0;
            for (k = 0; k < spill_fill; k++)
               if (spill_key[k] == j) begin
                  hit = 1;
                  break;
               end
            if (hit) begin
               res = spill_val[k];
               spill_val[k] = cur;
            end else begin
               res = lo_value + j;
               spill_key[spill_fill] = j;
               spill_val[spill_fill] = cur;
               spill_fill++;
            end
         end
         slot_val[i] = res;
         slot_set[i] = 1;
      end else begin
         res = lo_value + word % size;
      end
      d.value = res;
      d.position = i[5:0];
      d.final_draw = (i + 1 >= cnt);
      if (d.final_draw) clear_shuffle();
      else step_pos = i + 1;
      return d;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RANGE_MIN:    lo_value = data;
         CSR_RANGE_SIZE:   span = data[30:0];
         CSR_SAMPLE_COUNT: draws_per_run = data[6:0];
         CSR_NO_REPEATS:   distinct = data[0];
         default:          ;
      endcase
      clear_shuffle();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic setup(logic [31:0] lo, logic [31:0] sz, logic [31:0] cnt, logic rep);
      drain();
      write_csr(CSR_RANGE_MIN, lo);
      write_csr(CSR_RANGE_SIZE, sz);
      write_csr(CSR_SAMPLE_COUNT, cnt);
      write_csr(CSR_NO_REPEATS, rep);
   endtask

   // one word offered per call; burst gaps decided by caller
   task automatic send_word(logic [30:0] word, bit known, draw_type want);
      draw_type d;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, word};
      do @(posedge clock); while (!req_tready);
      d = next_draw(word);
      if (known && d != want) begin
         $error("directed row word %h: predictor %h vs table %h", word, d, want);
         failures++;
      end
      pending_draws.push_back(d);
   endtask

   task automatic send_run(int n, bit deep);
      int burst;
      logic [30:0] w;
      burst = 0;
      for (int m = 0; m < n; m++) begin
         if (burst == 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : 0) @(negedge clock);
            burst = $urandom_range(1, 12);
         end else begin
            @(negedge clock);
         end
         w = 31'($urandom);
         if (deep && $urandom_range(0, 2) == 0) w = 31'($urandom_range(0, 200));
         send_word(w, 1'b0, '0);
         burst--;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // result side: own stall pattern plus one long hold-off
   always @(negedge clock) begin
      if (hold_long) begin
         rsp_tready <= 1'b0;
         lag_cycles <= lag_cycles + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 7) < 3) ? ($urandom_range(0, 1) == 1) : 1'b1;
      end
   end

   always @(posedge clock) begin
      draw_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[37:32], rsp_tlast};
         if (pending_draws.size() == 0) begin
            $error("draw %h arrived with none expected", got);
            failures++;
         end else begin
            want = pending_draws.pop_front();
            if (got.value != want.value) begin
               $error("drawn_value expected %h actual %h", want.value, got.value);
               failures++;
            end
            if (got.position != want.position) begin
               $error("draw_number expected %0d actual %0d", want.position, got.position);
               failures++;
            end
            if (got.final_draw != want.final_draw) begin
               $error("last expected %b actual %b", want.final_draw, got.final_draw);
               failures++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   row_type rows [$];

   initial begin
      lo_value = 0;
      span = 1;
      draws_per_run = 1;
      distinct = 0;
      clear_shuffle();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: size 1, single draw, value 0 regardless of word
      rows.push_back('{31'h0, 1'b1, '{32'd0, 6'd0, 1'b1}});
      rows.push_back('{31'h7fffffff, 1'b1, '{32'd0, 6'd0, 1'b1}});
      foreach (rows[r]) begin
         @(negedge clock);
         send_word(rows[r].word, rows[r].known, rows[r].draw);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // extremes: wrap of min + offset, full size, zero size and count
      setup(32'h7fffffff, 32'h7fffffff, 7'd64, 1'b0);
      rows = {};
      rows.push_back('{31'h7ffffffe, 1'b1, '{32'hfffffffd, 6'd0, 1'b0}});
      rows.push_back('{31'h7fffffff, 1'b1, '{32'h7fffffff, 6'd1, 1'b0}});
      rows.push_back('{31'h1, 1'b1, '{32'h80000000, 6'd2, 1'b0}});
      foreach (rows[r]) begin
         @(negedge clock);
         send_word(rows[r].word, rows[r].known, rows[r].draw);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      setup(32'h80000000, 32'h0, 7'd0, 1'b1);
      @(negedge clock);
      send_word(31'h1234, 1'b1, '{32'h80000000, 6'd0, 1'b1});
      @(negedge clock);
      req_tvalid <= 1'b0;
      // count above size falls back to repeats; count above the maximum saturates
      setup(32'd10, 32'd3, 7'd5, 1'b1);
      send_run(6, 0);
      setup(32'hfffffff0, 32'd100, 7'd127, 1'b1);
      send_run(70, 0);
      // a config write mid-run abandons it
      setup(32'd0, 32'd8, 7'd8, 1'b1);
      send_run(3, 0);
      setup(32'd0, 32'd8, 7'd8, 1'b1);
      send_run(16, 0);

      // random phases, mostly distinct shuffles
      for (int p = 0; p < 22; p++) begin
         logic [31:0] sz;
         int cnt;
         cnt = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            0: sz = $urandom_range(1, 70);
            1: sz = $urandom_range(cnt, cnt + 5);
            2: sz = 32'h7fffffff - $urandom_range(0, 3);
            default: sz = $urandom >> 1;
         endcase
         setup($urandom, sz, cnt, $urandom_range(0, 3) != 0);
         if (p == 5) begin
            hold_long = 1;
            fork
               send_run(40, 1);
               begin
                  repeat (400) @(negedge clock);
                  hold_long = 0;
               end
            join
         end else begin
            send_run(45, (p % 2) == 0);
         end
         if (p == 10) drain();
      end

      drain();
      if (failures == 0 && pending_draws.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
